>>> hw/rtl/fhs_pkg.sv
// Shared constants, request codes and palette for the fire heat-spread block.
`timescale 1ns / 1ps

package fhs_pkg;

	// Field widths
	localparam int REQ_TYPE_W  = 2;
	localparam int COLUMN_W    = 8;
	localparam int PIXEL_ROW_W = 7;
	localparam int HEAT_W      = 6;
	localparam int COLOR_W     = 8;

	// Configuration register widths and port shape
	localparam int CFG_WIDTH_W = 9;
	localparam int CFG_ROWS_W  = 7;
	localparam int CFG_SEED_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

	// Configuration reset values
	localparam int                    CFG_WIDTH_RST = 80;
	localparam int                    CFG_ROWS_RST  = 24;
	localparam logic [CFG_SEED_W-1:0] CFG_SEED_RST  = 32'h9d2c5680;

	// Request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_INIT = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_STEP = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_READ = 2'd2;

	// Heat range
	localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

	// xorshift32 shift amounts
	localparam int RNG_SH_A = 13;
	localparam int RNG_SH_B = 17;
	localparam int RNG_SH_C = 5;

	// Palette: {red, green, blue}; heat above the top entry uses the top entry
	function automatic logic [3*COLOR_W-1:0] pal_rgb(input logic [HEAT_W-1:0] h);
		logic [3*COLOR_W-1:0] c;
		case (h)
			6'd0:    c = 24'h070707;
			6'd1:    c = 24'h1F0707;
			6'd2:    c = 24'h2F0F07;
			6'd3:    c = 24'h470F07;
			6'd4:    c = 24'h571707;
			6'd5:    c = 24'h671F07;
			6'd6:    c = 24'h771F07;
			6'd7:    c = 24'h8F2707;
			6'd8:    c = 24'h9F2F07;
			6'd9:    c = 24'hAF3F07;
			6'd10:   c = 24'hBF4707;
			6'd11:   c = 24'hC74707;
			6'd12:   c = 24'hDF4F07;
			6'd13:   c = 24'hDF5707;
			6'd14:   c = 24'hDF5707;
			6'd15:   c = 24'hD75F07;
			6'd16:   c = 24'hD75F07;
			6'd17:   c = 24'hD7670F;
			6'd18:   c = 24'hCF6F0F;
			6'd19:   c = 24'hCF770F;
			6'd20:   c = 24'hCF7F0F;
			6'd21:   c = 24'hCF8717;
			6'd22:   c = 24'hC78717;
			6'd23:   c = 24'hC78F17;
			6'd24:   c = 24'hC7971F;
			6'd25:   c = 24'hBF9F1F;
			6'd26:   c = 24'hBF9F1F;
			6'd27:   c = 24'hBFA727;
			6'd28:   c = 24'hBFA727;
			6'd29:   c = 24'hBFAF2F;
			6'd30:   c = 24'hB7AF2F;
			6'd31:   c = 24'hB7B72F;
			6'd32:   c = 24'hB7B737;
			6'd33:   c = 24'hCFCF6F;
			6'd34:   c = 24'hDFDF9F;
			6'd35:   c = 24'hEFEFC7;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/fhs_if.sv
// Request and response channel interfaces for the fire heat-spread block.
`timescale 1ns / 1ps

interface fhs_req_if;
	logic                               valid;
	logic                               ready;
	logic [fhs_pkg::REQ_TYPE_W-1:0]     req_type;
	logic [fhs_pkg::COLUMN_W-1:0]       column;
	logic [fhs_pkg::PIXEL_ROW_W-1:0]    pixel_row;

	modport source (output valid, output req_type, output column, output pixel_row,
		input ready);
	modport sink (input valid, input req_type, input column, input pixel_row,
		output ready);
endinterface

interface fhs_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [fhs_pkg::HEAT_W-1:0]         heat;
	logic [fhs_pkg::COLOR_W-1:0]        red;
	logic [fhs_pkg::COLOR_W-1:0]        green;
	logic [fhs_pkg::COLOR_W-1:0]        blue;

	modport source (output valid, output heat, output red, output green, output blue,
		input ready);
	modport sink (input valid, input heat, input red, input green, input blue,
		output ready);
endinterface

>>> hw/rtl/fire_heat_spread_step.sv
// Top level of the fire heat-spread block: sequencer, configuration and result register.
`timescale 1ns / 1ps

// Fire heat-spread engine. It keeps a heat map (heat 0..36 per pixel, stored flat at
// row*width+column) and a xorshift32 generator, and serves one request at a time on
// the req channel, returning exactly one response on rsp (heat plus palette colour for
// a read, all zeros for init, step, an unknown code or a read outside the map).
// A step walks every pixel below the top row once, one pixel per cycle through the
// single spread unit and the map's read and write ports. An init sweeps the whole
// store to zero one entry per cycle and then writes the bottom row. After reset the
// block runs the same clearing pass with the default 80x48 geometry, with req.ready
// low; configuration writes are taken throughout. Write configuration only while the
// block is idle. A finished response waits in the output register while the next
// request is taken.
module fire_heat_spread_step #(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_CELL_ROWS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	fhs_req_if.sink                            req,
	fhs_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [fhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fhs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int DEPTH = MAX_WIDTH * 2 * MAX_CELL_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int PRW   = $clog2(2 * MAX_CELL_ROWS + 1);
	localparam int RST_W = (fhs_pkg::CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH :
		fhs_pkg::CFG_WIDTH_RST;
	localparam int RST_PH = 2 * ((fhs_pkg::CFG_ROWS_RST > MAX_CELL_ROWS) ? MAX_CELL_ROWS :
		fhs_pkg::CFG_ROWS_RST);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_BASE  = 4'd2;
	localparam logic [3:0] S_FILL  = 4'd3;
	localparam logic [3:0] S_STEP  = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_RADDR = 4'd6;
	localparam logic [3:0] S_RMEM  = 4'd7;
	localparam logic [3:0] S_RDATA = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	// Configuration registers
	logic [fhs_pkg::CFG_WIDTH_W-1:0] cfg_width_q;
	logic [fhs_pkg::CFG_ROWS_W-1:0]  cfg_rows_q;
	logic [fhs_pkg::CFG_SEED_W-1:0]  cfg_seed_q;

	// Sequencer and datapath state
	logic [3:0]                      state_q;
	logic                            boot_q;
	logic [WW-1:0]                   w_q;
	logic [PRW-1:0]                  ph_q;
	logic [WW-1:0]                   x_q;
	logic [PRW-1:0]                  y_q;
	logic [AW-1:0]                   addr_q;
	logic [fhs_pkg::COLUMN_W-1:0]    col_q;
	logic [fhs_pkg::PIXEL_ROW_W-1:0] row_q;
	logic [fhs_pkg::CFG_SEED_W-1:0]  rng_q;
	logic                            v_s1;
	logic [AW-1:0]                   src_s1;
	logic [fhs_pkg::HEAT_W-1:0]      pend_heat_q;
	logic                            pend_hit_q;

	// Result register
	logic                            out_valid_q;
	logic [fhs_pkg::HEAT_W-1:0]      out_heat_q;
	logic [3*fhs_pkg::COLOR_W-1:0]   out_rgb_q;

	// Effective geometry and combinational controls
	logic [WW-1:0]                   w_eff;
	logic [PRW-1:0]                  cells_eff;
	logic [PRW-1:0]                  ph_eff;
	logic                            accept;
	logic                            load_out;
	logic                            row_last;
	logic                            col_last;

	// Map port signals
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [fhs_pkg::HEAT_W-1:0]      ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [fhs_pkg::HEAT_W-1:0]      ram_rdata;

	// Spread unit signals
	logic                            alu_adv;
	logic [fhs_pkg::CFG_SEED_W-1:0]  alu_rng;
	logic [AW-1:0]                   alu_waddr;
	logic [fhs_pkg::HEAT_W-1:0]      alu_wdata;

	// Saturate the programmed geometry to what the store holds
	always_comb begin
		if (cfg_width_q < fhs_pkg::CFG_WIDTH_W'(2)) begin
			w_eff = WW'(2);
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_width_q);
		end
		if (cfg_rows_q == '0) begin
			cells_eff = PRW'(1);
		end else if (32'(cfg_rows_q) > 32'(MAX_CELL_ROWS)) begin
			cells_eff = PRW'(MAX_CELL_ROWS);
		end else begin
			cells_eff = PRW'(cfg_rows_q);
		end
		ph_eff = cells_eff << 1;
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign row_last  = (y_q == ph_q - PRW'(1));
	assign col_last  = (x_q == w_q - WW'(1));

	// Configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q <= fhs_pkg::CFG_WIDTH_W'(fhs_pkg::CFG_WIDTH_RST);
			cfg_rows_q  <= fhs_pkg::CFG_ROWS_W'(fhs_pkg::CFG_ROWS_RST);
			cfg_seed_q  <= fhs_pkg::CFG_SEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fhs_pkg::CFG_WIDTH: cfg_width_q <= cfg_wdata[fhs_pkg::CFG_WIDTH_W-1:0];
				fhs_pkg::CFG_ROWS:  cfg_rows_q  <= cfg_wdata[fhs_pkg::CFG_ROWS_W-1:0];
				fhs_pkg::CFG_SEED:  cfg_seed_q  <= cfg_wdata[fhs_pkg::CFG_SEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Map port steering: clear and fill write through addr_q, the walk writes
	// the previous pixel's target while it reads the next pixel
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = fhs_pkg::HEAT_MAX;
			end
			S_STEP, S_DRAIN: begin
				ram_we    = v_s1;
				ram_waddr = alu_waddr;
				ram_wdata = alu_wdata;
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			w_q         <= WW'(RST_W);
			ph_q        <= PRW'(RST_PH);
			x_q         <= '0;
			y_q         <= '0;
			addr_q      <= '0;
			rng_q       <= fhs_pkg::CFG_SEED_RST;
			v_s1        <= 1'b0;
			pend_hit_q  <= 1'b0;
			pend_heat_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						w_q         <= w_eff;
						ph_q        <= ph_eff;
						x_q         <= '0;
						y_q         <= PRW'(1);
						v_s1        <= 1'b0;
						pend_hit_q  <= 1'b0;
						pend_heat_q <= '0;
						case (req.req_type)
							fhs_pkg::REQ_INIT: begin
								addr_q  <= '0;
								rng_q   <= cfg_seed_q;
								state_q <= S_CLEAR;
							end
							fhs_pkg::REQ_STEP: begin
								// first pixel walked is column 0 of row 1
								addr_q  <= AW'(w_eff);
								state_q <= S_STEP;
							end
							fhs_pkg::REQ_READ: begin
								if (32'(req.column) < 32'(w_eff) &&
									32'(req.pixel_row) < 32'(ph_eff)) begin
									state_q <= S_RADDR;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(DEPTH - 1)) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					// start of the bottom row
					addr_q  <= AW'((32'(ph_q) - 32'd1) * 32'(w_q));
					x_q     <= '0;
					state_q <= S_FILL;
				end
				S_FILL: begin
					addr_q <= addr_q + AW'(1);
					x_q    <= x_q + WW'(1);
					if (col_last) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_DONE;
					end
				end
				S_STEP: begin
					v_s1   <= 1'b1;
					src_s1 <= addr_q;
					if (v_s1 && alu_adv) begin
						rng_q <= alu_rng;
					end
					if (row_last) begin
						if (col_last) begin
							state_q <= S_DRAIN;
						end else begin
							x_q    <= x_q + WW'(1);
							y_q    <= PRW'(1);
							addr_q <= AW'(w_q) + AW'(x_q) + AW'(1);
						end
					end else begin
						y_q    <= y_q + PRW'(1);
						addr_q <= addr_q + AW'(w_q);
					end
				end
				S_DRAIN: begin
					v_s1 <= 1'b0;
					if (alu_adv) begin
						rng_q <= alu_rng;
					end
					state_q <= S_DONE;
				end
				S_RADDR: begin
					addr_q  <= AW'(32'(row_q) * 32'(w_q) + 32'(col_q));
					state_q <= S_RMEM;
				end
				S_RMEM: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					pend_heat_q <= ram_rdata;
					pend_hit_q  <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Read coordinates ride with the request
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= req.column;
			row_q <= req.pixel_row;
		end
	end

	// Result register: hold until taken, reload only when empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_heat_q <= pend_heat_q;
			out_rgb_q  <= pend_hit_q ? fhs_pkg::pal_rgb(pend_heat_q) : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.heat  = out_heat_q;
	assign rsp.red   = out_rgb_q[3*fhs_pkg::COLOR_W-1:2*fhs_pkg::COLOR_W];
	assign rsp.green = out_rgb_q[2*fhs_pkg::COLOR_W-1:fhs_pkg::COLOR_W];
	assign rsp.blue  = out_rgb_q[fhs_pkg::COLOR_W-1:0];

	fhs_heat_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_heat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fhs_spread_alu #(
		.AW (AW),
		.WW (WW)
	) u_spread_alu (
		.p       (ram_rdata),
		.src     (src_s1),
		.w       (w_q),
		.rng     (rng_q),
		.adv     (alu_adv),
		.rng_nxt (alu_rng),
		.waddr   (alu_waddr),
		.wdata   (alu_wdata)
	);

endmodule

>>> hw/rtl/fhs_heat_ram.sv
// Heat map store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fhs_heat_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [fhs_pkg::HEAT_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [fhs_pkg::HEAT_W-1:0]  rdata
);

	logic [fhs_pkg::HEAT_W-1:0] mem [DEPTH];
	logic [fhs_pkg::HEAT_W-1:0] rdata_q;

	// A read at the address being written returns the new contents: the walk
	// reads the next pixel in the same cycle that the previous pixel's target
	// is written, and that target can be the very pixel read next
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fhs_spread_alu.sv
// Spread unit: advances the generator and forms the target address and heat of one pixel.
`timescale 1ns / 1ps

module fhs_spread_alu #(
	parameter int AW = 15,
	parameter int WW = 9
) (
	input  logic [fhs_pkg::HEAT_W-1:0]      p,
	input  logic [AW-1:0]                   src,
	input  logic [WW-1:0]                   w,
	input  logic [fhs_pkg::CFG_SEED_W-1:0]  rng,
	output logic                            adv,
	output logic [fhs_pkg::CFG_SEED_W-1:0]  rng_nxt,
	output logic [AW-1:0]                   waddr,
	output logic [fhs_pkg::HEAT_W-1:0]      wdata
);

	logic [fhs_pkg::CFG_SEED_W-1:0] s0;
	logic [fhs_pkg::CFG_SEED_W-1:0] s1;
	logic [1:0]                     r;
	logic [AW:0]                    up;
	logic [AW:0]                    lo;

	always_comb begin
		s0      = rng ^ (rng << fhs_pkg::RNG_SH_A);
		s1      = s0 ^ (s0 >> fhs_pkg::RNG_SH_B);
		rng_nxt = s1 ^ (s1 << fhs_pkg::RNG_SH_C);
		r       = rng_nxt[1:0];
		adv     = (p != '0);
		up      = (AW+1)'(src) + (AW+1)'(1);
		lo      = (AW+1)'(w) + (AW+1)'(r);
		if (!adv) begin
			// cold pixel: kill the pixel directly above
			waddr = src - AW'(w);
			wdata = '0;
		end else begin
			// drift left by r-1, clamp at the first pixel of the map
			waddr = (up < lo) ? '0 : AW'(up - lo);
			wdata = p - fhs_pkg::HEAT_W'(r[0]);
		end
	end

endmodule

>>> hw/rtl/fhs_checker.sv
// Port-level checker for the fire heat-spread block and its bind.
`timescale 1ns / 1ps

module fhs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [fhs_pkg::HEAT_W-1:0]    rsp_heat,
	input logic [fhs_pkg::COLOR_W-1:0]   rsp_red,
	input logic [fhs_pkg::COLOR_W-1:0]   rsp_green,
	input logic [fhs_pkg::COLOR_W-1:0]   rsp_blue
);

	// One request at a time: no request is taken right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous request in progress");

	// A fresh response only follows a busy cycle
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without request work");

	// Stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("response dropped while stalled");

	// Stalled payload holds
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_heat) && $stable(rsp_red) &&
		$stable(rsp_green) && $stable(rsp_blue)))
		else $error("response payload changed while stalled");

endmodule

bind fire_heat_spread_step fhs_checker u_fhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_heat  (rsp.heat),
	.rsp_red   (rsp.red),
	.rsp_green (rsp.green),
	.rsp_blue  (rsp.blue)
);
